FILE: hdl/speed_scheduled_damping_torque_core_defines.svh
// Assertion macros used by the checker file of the damping torque core.
`ifndef SPEED_SCHEDULED_DAMPING_TORQUE_CORE_DEFINES_SVH
`define SPEED_SCHEDULED_DAMPING_TORQUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ssdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssdt_pkg;

  localparam int TORQUE_FRAC_BITS_DEF = 12;

  localparam int SPEED_W    = 12;
  localparam int VEL_W      = 16;
  localparam int ABS_W      = VEL_W + 1;
  localparam int GAIN_W     = 16;
  localparam int BS_W       = 11;
  localparam int LIM_W      = 14;
  localparam int STEP_W     = 12;
  localparam int OUT_W      = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_SPEED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP   = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0] BASE_GAIN_RST   = GAIN_W'(13107);
  localparam logic [BS_W-1:0]   BREAK_SPEED_RST = BS_W'(600);
  localparam logic [LIM_W-1:0]  MAX_TORQUE_RST  = LIM_W'(4506);
  localparam logic [STEP_W-1:0] RATE_STEP_RST   = STEP_W'(49);

endpackage

`default_nettype wire

FILE: hdl/ssdt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssdt_in_if;
  import ssdt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [SPEED_W-1:0] vehicle_speed;
  logic signed [VEL_W-1:0]   rack_velocity;
  modport source (output valid, output vehicle_speed, output rack_velocity, input ready);
  modport sink (input valid, input vehicle_speed, input rack_velocity, output ready);
endinterface

interface ssdt_out_if;
  import ssdt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] damping_torque;
  modport source (output valid, output damping_torque, input ready);
  modport sink (input valid, input damping_torque, output ready);
endinterface

interface ssdt_cfg_if;
  import ssdt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/speed_scheduled_damping_torque_core.sv
// Channel   Role    Payload
// sample    sink    vehicle_speed, rack_velocity
// result    source  damping_torque
// cfg       sink    index, data (always ready)
//
// An accepted item passes in order through the product, the restoring
// divide-step unit, the multiply, the slew and the output load. The input
// is ready again in the cycle after the load, so the block takes no new item
// before the previous one has been loaded.
// Reset is synchronous and restores the register defaults and a zero last torque for the slew.
// A waiting result does not block the next item; only the final load waits.
`timescale 1ns / 1ps
`default_nettype none

module speed_scheduled_damping_torque_core #(
  parameter int TORQUE_FRAC_BITS = ssdt_pkg::TORQUE_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ssdt_in_if.sink    sample,
  ssdt_out_if.source result,
  ssdt_cfg_if.sink   cfg
);
  import ssdt_pkg::*;

  localparam int SHIFT = 26 - TORQUE_FRAC_BITS;
  localparam int PW    = GAIN_W + ABS_W;
  localparam int SW    = PW + 2;
  localparam int DVD_W = GAIN_W + SPEED_W;
  localparam int CNT_W = $clog2(DVD_W);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PROD = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SLEW = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] base_gain;
  logic [BS_W-1:0]   break_speed;
  logic [LIM_W-1:0]  max_torque;
  logic [STEP_W-1:0] rate_step;

  logic signed [OUT_W-1:0] last_torque;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_torque;

  logic        [SPEED_W-1:0] speed;
  logic signed [VEL_W-1:0]   vel;
  logic        [DVD_W-1:0]   dvd;
  logic        [BS_W-1:0]    rem;
  logic        [CNT_W-1:0]   cnt;
  logic        [PW-1:0]      prod;
  logic signed [SW-1:0]      slew;

  logic [BS_W:0]       trial;
  logic [BS_W:0]       trial_sub;
  logic                fits;
  logic [GAIN_W-1:0]   gain;
  logic [ABS_W-1:0]    vel_wide;
  logic [ABS_W-1:0]    vel_abs;
  logic [PW-1:0]       mag;
  logic signed [SW-1:0] mag_s;
  logic signed [SW-1:0] trq;
  logic signed [SW-1:0] last_ext;
  logic signed [SW-1:0] step_ext;
  logic signed [SW-1:0] lim_ext;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] slew_next;
  logic signed [SW-1:0] clamped;
  logic                 load;

  assign sample.ready          = (state == ST_IDLE);
  assign cfg.ready             = 1'b1;
  assign result.valid          = out_valid;
  assign result.damping_torque = out_torque;

  always_comb begin
    trial     = {rem, dvd[DVD_W-1]};
    fits      = (trial >= {1'b0, break_speed});
    trial_sub = trial - {1'b0, break_speed};

    if (break_speed == '0) begin
      gain = '0;
    end else if (speed > {1'b0, break_speed}) begin
      gain = base_gain;
    end else begin
      gain = dvd[GAIN_W-1:0];
    end

    vel_wide = {vel[VEL_W-1], vel};
    vel_abs  = vel[VEL_W-1] ? (~vel_wide + ABS_W'(1)) : vel_wide;

    mag      = prod >> SHIFT;
    mag_s    = $signed({2'b00, mag});
    trq      = vel[VEL_W-1] ? -mag_s : mag_s;
    last_ext = SW'(last_torque);
    step_ext = $signed({{(SW - STEP_W){1'b0}}, rate_step});
    lim_ext  = $signed({{(SW - LIM_W){1'b0}}, max_torque});
    diff     = trq - last_ext;

    if (diff > step_ext) begin
      slew_next = last_ext + step_ext;
    end else if (diff < -step_ext) begin
      slew_next = last_ext - step_ext;
    end else begin
      slew_next = trq;
    end

    if (slew > lim_ext) begin
      clamped = lim_ext;
    end else if (slew < -lim_ext) begin
      clamped = -lim_ext;
    end else begin
      clamped = slew;
    end

    load = (state == ST_DONE) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      out_valid   <= 1'b0;
      last_torque <= '0;
      base_gain   <= BASE_GAIN_RST;
      break_speed <= BREAK_SPEED_RST;
      max_torque  <= MAX_TORQUE_RST;
      rate_step   <= RATE_STEP_RST;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_BASE_GAIN:   base_gain   <= cfg.data[GAIN_W-1:0];
          REG_BREAK_SPEED: break_speed <= cfg.data[BS_W-1:0];
          REG_MAX_TORQUE:  max_torque  <= cfg.data[LIM_W-1:0];
          REG_RATE_STEP:   rate_step   <= cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end

      if (load) begin
        out_valid   <= 1'b1;
        last_torque <= clamped[OUT_W-1:0];
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          cnt   <= CNT_W'(DVD_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_SLEW;
        ST_SLEW: state <= ST_DONE;
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && sample.valid) begin
      speed <= sample.vehicle_speed;
      vel   <= sample.rack_velocity;
    end
    case (state)
      ST_PROD: begin
        dvd <= DVD_W'(base_gain) * DVD_W'(speed);
        rem <= '0;
      end
      ST_DIV: begin
        rem <= fits ? trial_sub[BS_W-1:0] : trial[BS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], fits};
      end
      ST_MUL:  prod <= PW'(gain) * PW'(vel_abs);
      ST_SLEW: slew <= slew_next;
      default: ;
    endcase
    if (load) begin
      out_torque <= clamped[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ssdt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "speed_scheduled_damping_torque_core_defines.svh"

module ssdt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [ssdt_pkg::OUT_W-1:0]    damping_torque,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);
  import ssdt_pkg::*;

  logic [OUT_W-1:0] torque_seen;

  assign torque_seen = damping_torque;

  // An accepted item keeps the block busy for the following cycle.
  `SSDT_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "ready after accept")
  // A new result appears only as the block finishes an item and turns ready.
  `SSDT_ASSERT_NOW(a_result_on_finish, $rose(result_valid), sample_ready && $past(!sample_ready), "result out of sequence")
  // A stalled result stays and keeps its value.
  `SSDT_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(torque_seen), "stalled result changed")
  // Register writes are never refused.
  `SSDT_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind speed_scheduled_damping_torque_core ssdt_checker u_ssdt_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample.valid),
  .sample_ready   (sample.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .damping_torque (result.damping_torque),
  .cfg_valid      (cfg.valid),
  .cfg_ready      (cfg.ready)
);

`default_nettype wire
